FILE: rtl/scdp_pkg.sv
// ----------------------------------------------------------------------------
// scdp_pkg
// Shared types and constants of the serial drive command parser: character
// codes, command codes, reset values, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scdp_pkg;

  localparam int LINE_DEPTH_DEF = 256;

  // received characters
  localparam logic [7:0] ASC_CR    = 8'h0D;
  localparam logic [7:0] ASC_SPACE = 8'h20;
  localparam logic [7:0] ASC_0     = 8'h30;
  localparam logic [7:0] ASC_9     = 8'h39;
  localparam logic [7:0] ASC_A     = 8'h61;
  localparam logic [7:0] ASC_B     = 8'h62;
  localparam logic [7:0] ASC_Z     = 8'h7A;

  // line store entry for a space; digits are stored as 0..9
  localparam logic [3:0] SPACE_CODE = 4'd10;

  // pending command codes: letter - 'a' + 1, zero for none
  localparam logic [4:0] CMD_NONE = 5'd0;
  localparam logic [4:0] CMD_A    = 5'd1;
  localparam logic [4:0] CMD_D    = 5'd4;
  localparam logic [4:0] CMD_Q    = 5'd17;
  localparam logic [4:0] CMD_R    = 5'd18;
  localparam logic [4:0] CMD_S    = 5'd19;
  localparam logic [4:0] CMD_T    = 5'd20;
  localparam logic [4:0] CMD_W    = 5'd23;
  localparam logic [4:0] CMD_Z    = 5'd26;

  localparam logic signed [1:0] DIR_NEG  = -2'sd1;
  localparam logic signed [1:0] DIR_ZERO = 2'sd0;
  localparam logic signed [1:0] DIR_POS  = 2'sd1;

  localparam logic [6:0]  RESET_SPEED_LIMIT = 7'd100;
  localparam logic [15:0] RESET_TURN_RATE   = 16'd9000;
  localparam logic [15:0] RESET_ACCEL       = 16'd4900;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRIME,
    ST_SCAN,
    ST_EXEC,
    ST_PUBLISH
  } scdp_state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic prime;
    logic step;
    logic exec;
    logic publish;
  } scdp_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic line_empty;
    logic scan_last;
    logic out_busy;
  } scdp_stat_t;

endpackage

FILE: rtl/scdp_ctrl.sv
// ----------------------------------------------------------------------------
// scdp_ctrl
// Sequencer of the parser: takes a request, decodes it and, on carriage
// return, walks the line store unless it is empty and applies the command;
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module scdp_ctrl
  import scdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  scdp_stat_t stat,
  output scdp_cmd_t  cmd,
  output logic       idle
);

  scdp_state_t state_r;
  scdp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    idle      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (!stat.is_cr) begin
          state_nxt = ST_PUBLISH;
        end else if (stat.line_empty) begin
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        // hold until the previous result has been taken
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/scdp_dp.sv
// ----------------------------------------------------------------------------
// scdp_dp
// Datapath of the parser: line store memory, fill count, pending command,
// decimal accumulator, drive registers, speed limit and output register.
// ----------------------------------------------------------------------------
module scdp_dp
  import scdp_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  scdp_cmd_t         cmd,
  output scdp_stat_t        stat,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_drive_speed,
  output logic signed [1:0] out_drive_direction,
  output logic signed [1:0] out_turn_direction,
  output logic [15:0]       out_turn_rate,
  output logic [15:0]       out_accel_rate,
  output logic              out_line_done
);

  localparam int IDXW = $clog2(LINE_DEPTH);
  localparam int CNTW = $clog2(LINE_DEPTH + 1);

  logic [3:0] line_mem [LINE_DEPTH];
  logic [3:0] rd_data_r;
  logic [IDXW-1:0] rd_addr;
  logic            wr_en;
  logic [3:0]      wr_data;

  logic [7:0]      rx_r;
  logic [CNTW-1:0] fill_r, fill_nxt;
  logic [4:0]      pcmd_r, pcmd_nxt;
  logic [CNTW-1:0] ptr_r, ptr_nxt;
  logic [CNTW-1:0] ptr_inc;
  logic [15:0]     acc_r, acc_nxt;
  logic [15:0]     acc_new;
  logic [15:0]     last_r, last_nxt;
  logic [6:0]      limit_r;
  logic [6:0]      speed_r, speed_nxt;
  logic signed [1:0] dir_r, dir_nxt;
  logic signed [1:0] turn_r, turn_nxt;
  logic [15:0]     rate_r, rate_nxt;
  logic [15:0]     accel_r, accel_nxt;
  logic            done_r;
  logic            out_valid_r;
  logic            is_space;

  logic [6:0]        o_speed_r;
  logic signed [1:0] o_dir_r;
  logic signed [1:0] o_turn_r;
  logic [15:0]       o_rate_r;
  logic [15:0]       o_accel_r;
  logic              o_done_r;

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[fill_r[IDXW-1:0]] <= wr_data;
    end
    rd_data_r <= line_mem[rd_addr];
  end

  assign ptr_inc  = ptr_r + CNTW'(1);
  assign rd_addr  = cmd.prime ? '0 : ptr_inc[IDXW-1:0];
  assign is_space = (rd_data_r == SPACE_CODE);
  assign acc_new  = is_space ? acc_r
                             : (acc_r << 3) + (acc_r << 1) + {12'd0, rd_data_r};

  assign stat.is_cr      = (rx_r == ASC_CR);
  assign stat.line_empty = (fill_r == '0);
  assign stat.scan_last  = is_space || (ptr_inc == fill_r);
  assign stat.out_busy   = out_valid_r && out_stall;

  always_comb begin
    fill_nxt  = fill_r;
    pcmd_nxt  = pcmd_r;
    ptr_nxt   = ptr_r;
    acc_nxt   = acc_r;
    last_nxt  = last_r;
    speed_nxt = speed_r;
    dir_nxt   = dir_r;
    turn_nxt  = turn_r;
    rate_nxt  = rate_r;
    accel_nxt = accel_r;
    wr_en     = 1'b0;
    wr_data   = 4'(rx_r - ASC_0);

    if (cmd.decode) begin
      case (rx_r) inside
        [ASC_0:ASC_9], ASC_SPACE: begin
          // drop characters once the line is full
          if (fill_r < CNTW'(LINE_DEPTH)) begin
            wr_en    = 1'b1;
            wr_data  = (rx_r == ASC_SPACE) ? SPACE_CODE : 4'(rx_r - ASC_0);
            fill_nxt = fill_r + CNTW'(1);
          end
        end
        ASC_B: begin
          if (fill_r != '0) begin
            fill_nxt = fill_r - CNTW'(1);
          end
        end
        [ASC_A:ASC_Z]: begin
          pcmd_nxt = 5'(rx_r - ASC_A + 8'd1);
        end
        default: begin
        end
      endcase
    end

    if (cmd.prime) begin
      ptr_nxt = '0;
      acc_nxt = '0;
    end

    if (cmd.step) begin
      ptr_nxt = ptr_inc;
      acc_nxt = acc_new;
      if (stat.scan_last) begin
        last_nxt = acc_new;
      end
    end

    if (cmd.exec) begin
      case (pcmd_r)
        CMD_W: dir_nxt  = (dir_r == DIR_POS) ? DIR_ZERO : DIR_POS;
        CMD_S: dir_nxt  = (dir_r == DIR_NEG) ? DIR_ZERO : DIR_NEG;
        CMD_A: turn_nxt = (turn_r == DIR_NEG) ? DIR_ZERO : DIR_NEG;
        CMD_D: turn_nxt = (turn_r == DIR_POS) ? DIR_ZERO : DIR_POS;
        CMD_T: begin
          if (last_r <= {9'd0, limit_r}) begin
            speed_nxt = last_r[6:0];
          end
        end
        CMD_R: rate_nxt  = last_r;
        CMD_Q: accel_nxt = last_r;
        CMD_Z: begin
          speed_nxt = '0;
          dir_nxt   = DIR_ZERO;
          turn_nxt  = DIR_ZERO;
        end
        default: begin
        end
      endcase
      pcmd_nxt = CMD_NONE;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pcmd_r      <= CMD_NONE;
      last_r      <= '0;
      limit_r     <= RESET_SPEED_LIMIT;
      speed_r     <= '0;
      dir_r       <= DIR_ZERO;
      turn_r      <= DIR_ZERO;
      rate_r      <= RESET_TURN_RATE;
      accel_r     <= RESET_ACCEL;
      out_valid_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      pcmd_r  <= pcmd_nxt;
      last_r  <= last_nxt;
      speed_r <= speed_nxt;
      dir_r   <= dir_nxt;
      turn_r  <= turn_nxt;
      rate_r  <= rate_nxt;
      accel_r <= accel_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    acc_r <= acc_nxt;
    if (cmd.capture) begin
      rx_r <= in_rx_byte;
    end
    if (cmd.decode) begin
      done_r <= stat.is_cr;
    end
    if (cmd.publish) begin
      o_speed_r <= speed_r;
      o_dir_r   <= dir_r;
      o_turn_r  <= turn_r;
      o_rate_r  <= rate_r;
      o_accel_r <= accel_r;
      o_done_r  <= done_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_speed     = o_speed_r;
  assign out_drive_direction = o_dir_r;
  assign out_turn_direction  = o_turn_r;
  assign out_turn_rate       = o_rate_r;
  assign out_accel_rate      = o_accel_r;
  assign out_line_done       = o_done_r;

endmodule

FILE: rtl/serial_drive_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_drive_command_parser_unit
// Builds drive settings from text lines received one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_rx_byte carries one received character
//   per request. Every request yields exactly one result on the out_ channel:
//   the drive settings after that character, with out_line_done set when the
//   character was a carriage return and the line was executed.
//   cfg_wr_en/cfg_wr_data write the speed limit; the user must do so only
//   while the block is idle, as the block itself does not enforce it.
// Sequence:
//   A character other than carriage return is captured, decoded and published
//   before the next is accepted. A carriage return also passes prime, a scan of
//   the line store entries up to and including the first space (at most
//   LINE_DEPTH; one read port, the accumulator takes one entry per cycle) and
//   execute; on an empty line prime and scan are skipped.
// Reset (rst_n low, synchronous): empty line, no pending command, speed and
//   directions zero, turn rate 9000, acceleration 4900, speed limit 100.
// A stalled result holds in the output register; the next request is taken
//   meanwhile, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module serial_drive_command_parser_unit
  import scdp_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_drive_speed,
  output logic signed [1:0] out_drive_direction,
  output logic signed [1:0] out_turn_direction,
  output logic [15:0]       out_turn_rate,
  output logic [15:0]       out_accel_rate,
  output logic              out_line_done
);

  scdp_cmd_t  cmd;
  scdp_stat_t stat;
  logic       idle;

  assign in_stall = !idle;

  scdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  scdp_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_rx_byte          (in_rx_byte),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_speed     (out_drive_speed),
    .out_drive_direction (out_drive_direction),
    .out_turn_direction  (out_turn_direction),
    .out_turn_rate       (out_turn_rate),
    .out_accel_rate      (out_accel_rate),
    .out_line_done       (out_line_done)
  );

endmodule

FILE: rtl/scdp_chk.sv
// ----------------------------------------------------------------------------
// scdp_chk
// Port-level checks of the serial drive command parser, bound to the top.
// ----------------------------------------------------------------------------
module scdp_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [1:0] out_drive_direction,
  input logic signed [1:0] out_turn_direction
);

  // one request at a time: stall right after an accepted request
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while a previous one is in work");

  // a result appears only as the sequencer returns to idle
  a_publish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result published while a request is still in work");

  // the unused two-bit code never shows on either direction
  a_dir_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_direction != 2'b10) && (out_turn_direction != 2'b10))
    else $error("direction output holds the unused code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind serial_drive_command_parser_unit scdp_chk u_chk (.*);
